// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the percent decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/pct_pkg.sv =====
// Package: types, character constants and hex, whitespace and plus helpers for the percent decoder.
`timescale 1ns / 1ps
package pct_pkg;

  localparam int unsigned MAX_RES = 3;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_PCT   = 2'd1,
    PH_PAIR  = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] first;
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    logic [MAX_RES-1:0][7:0]     bytes;
  } res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

endpackage

// ===== rtl/core/pct_if.sv =====
// Valid/ready stream interfaces for encoded input and decoded output items.
`timescale 1ns / 1ps
interface pct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

// ===== rtl/core/pct_decode.sv =====
// Combinational decode of one input byte into up to three output bytes.
`timescale 1ns / 1ps
module pct_decode import pct_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output state_t     state_o,
  output res_t       res_o
);

  logic [4:0]       ha, hb;
  logic             pair_ok;
  logic [7:0]       pair_v;
  logic [7:0]       a;
  logic [CNT_W-1:0] n;

  assign a  = state_i.first;
  assign ha = hex_val(a);
  assign hb = hex_val(byte_i);

  always_comb begin
    pair_ok = 1'b0;
    pair_v  = 8'd0;
    if (ha[4]) begin
      pair_ok = 1'b1;
      pair_v  = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
    end else if (hb[4]) begin
      if (is_ws(a) || a == CHAR_PLUS) begin
        pair_ok = 1'b1;
        pair_v  = {4'd0, hb[3:0]};
      end else if (a == CHAR_MINUS) begin
        pair_ok = 1'b1;
        pair_v  = 8'd0 - {4'd0, hb[3:0]};
      end
    end
  end

  always_comb begin
    n             = '0;
    res_o.bytes   = '0;
    state_o.phase = PH_PLAIN;
    state_o.first = state_i.first;
    case (state_i.phase)
      PH_PCT: begin
        if (last_i) begin
          res_o.bytes[0] = CHAR_PERCENT;
          res_o.bytes[1] = plain(byte_i);
          n = CNT_W'(2);
        end else begin
          state_o.first = byte_i;
          state_o.phase = PH_PAIR;
        end
      end
      PH_PAIR: begin
        if (pair_ok) begin
          res_o.bytes[0] = pair_v;
          n = CNT_W'(1);
        end else begin
          res_o.bytes[0] = CHAR_PERCENT;
          n = CNT_W'(1);
          if (a == CHAR_PERCENT && !last_i) begin
            // percent as first pair char reopens an escape
            state_o.first = byte_i;
            state_o.phase = PH_PAIR;
          end else begin
            res_o.bytes[1] = plain(a);
            n = CNT_W'(2);
            if (byte_i == CHAR_PERCENT && !last_i) begin
              state_o.phase = PH_PCT;
            end else begin
              res_o.bytes[2] = plain(byte_i);
              n = CNT_W'(3);
            end
          end
        end
      end
      default: begin
        if (byte_i == CHAR_PERCENT && !last_i) begin
          state_o.phase = PH_PCT;
        end else begin
          res_o.bytes[0] = plain(byte_i);
          n = CNT_W'(1);
        end
      end
    endcase
    if (last_i) begin
      state_o.phase = PH_PLAIN;
    end
    res_o.cnt = n;
  end

endmodule

// ===== rtl/core/percent_decoder.sv =====
// Top level of the URL percent decoder.
// The decoded bytes are registered: the first is offered in the cycle after its input item is accepted.
// Throughput: one output byte per cycle while out_o.ready is high; an item that yields more than one byte
// holds off the next input item until its last byte is being taken from the result buffer.
// Reset (rst_ni low, async): back to plain text, result buffer empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module percent_decoder import pct_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  pct_in_if.sink          in_i,
  pct_out_if.source       out_o
);

  state_t                  state_q, state_d;
  res_t                    res_d;
  logic [MAX_RES-1:0][7:0] buf_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    last_q;
  logic                    in_fire, out_fire;

  pct_decode u_decode (
    .state_i (state_q),
    .byte_i  (in_i.in_byte),
    .last_i  (in_i.in_last),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == '0) || (cnt_q == CNT_W'(1) && out_o.ready);
  assign in_fire  = in_i.valid && in_i.ready;

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.out_byte   = buf_q[0];
  assign out_o.run_end    = (cnt_q == CNT_W'(1));
  assign out_o.string_end = (cnt_q == CNT_W'(1)) && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= PH_PLAIN;
      state_q.first <= 8'h00;
      cnt_q         <= '0;
      last_q        <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q.phase <= state_d.phase;
        state_q.first <= state_d.first;
        cnt_q         <= res_d.cnt;
        last_q        <= in_i.in_last;
      end else if (out_fire) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buf_q <= res_d.bytes;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  `ASSERT_PROP(a_in_only_when_drained, clk_i, rst_ni,
               in_fire |-> (cnt_q == '0 || (cnt_q == CNT_W'(1) && out_fire)),
               "item accepted with results pending")
  `ASSERT_PROP(a_drain_step, clk_i, rst_ni,
               (out_fire && !in_fire) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)),
               "result count did not step down")
  `ASSERT_PROP(a_last_to_plain, clk_i, rst_ni,
               (in_fire && in_i.in_last) |=> (state_q.phase == PH_PLAIN),
               "escape open after end of string")
  `ASSERT_PROP(a_last_yields, clk_i, rst_ni,
               (in_fire && in_i.in_last) |=> (cnt_q != '0 && last_q),
               "final byte produced no result")

endmodule

// ===== bench/tb_percent_decoder.sv =====
// Self-checking testbench for the URL percent decoder: directed strings, random strings, stalls.
`timescale 1ns / 1ps
module tb_percent_decoder import pct_pkg::*; ();

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES    = 80;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } dec_byte_t;

  logic clk_i;
  logic rst_ni;

  pct_in_if  in_if ();
  pct_out_if out_if ();

  percent_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decoder mirror state
  phase_e     esc_phase;
  logic [7:0] pair_first;
  dec_byte_t  decoded_q[$];

  logic [7:0] str_buf[$];
  int src_idle_pct;
  int sink_idle_pct;
  int hold_seq;
  int hold_len;
  int hold_seen;
  int hold_left;
  int fail_count;
  int items_sent;
  int items_taken;
  int bytes_checked;
  int strings_sent;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int nibble(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] to_space(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

  // {valid, value} of a hex pair, parsed the strtol way
  function automatic logic [8:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    int ha;
    int hb;
    ha = nibble(a);
    hb = nibble(b);
    if (ha >= 0) return {1'b1, (hb >= 0) ? 8'(ha * 16 + hb) : 8'(ha)};
    if (hb < 0) return 9'd0;
    if (a == CHAR_SPACE || (a >= CHAR_TAB && a <= CHAR_CR) || a == CHAR_PLUS)
      return {1'b1, 8'(hb)};
    if (a == CHAR_MINUS) return {1'b1, 8'(256 - hb)};
    return 9'd0;
  endfunction

  task automatic decode_item(input logic [7:0] c, input logic last);
    logic [7:0] produced[$];
    logic [8:0] pv;
    logic       do_plain;
    phase_e     ph;
    dec_byte_t  d;
    ph        = esc_phase;
    esc_phase = PH_PLAIN;
    do_plain  = 1'b0;
    case (ph)
      PH_PCT: begin
        if (last) begin
          produced.push_back(CHAR_PERCENT);
          produced.push_back(to_space(c));
        end else begin
          pair_first = c;
          esc_phase  = PH_PAIR;
        end
      end
      PH_PAIR: begin
        pv = pair_value(pair_first, c);
        if (pv[8]) begin
          produced.push_back(pv[7:0]);
        end else begin
          produced.push_back(CHAR_PERCENT);
          // a second '%' restarts the escape with c as its first char
          if (pair_first == CHAR_PERCENT && !last) begin
            pair_first = c;
            esc_phase  = PH_PAIR;
          end else begin
            produced.push_back(to_space(pair_first));
            do_plain = 1'b1;
          end
        end
      end
      default: do_plain = 1'b1;
    endcase
    if (do_plain) begin
      if (c == CHAR_PERCENT && !last) esc_phase = PH_PCT;
      else produced.push_back(to_space(c));
    end
    if (last) esc_phase = PH_PLAIN;
    foreach (produced[i]) begin
      d.data       = produced[i];
      d.run_end    = (i == produced.size() - 1);
      d.string_end = (i == produced.size() - 1) && last;
      decoded_q.push_back(d);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("ERROR @%0t: %s got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Input/output monitor, result check and watchdog
  always @(posedge clk_i) begin
    dec_byte_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_if.valid && in_if.ready) begin
        decode_item(in_if.in_byte, in_if.in_last);
        items_taken++;
        quiet_cycles = 0;
      end
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        bytes_checked++;
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_if.out_byte, 8'h00);
        end else begin
          want = decoded_q.pop_front();
          if (out_if.out_byte !== want.data)
            report_mismatch("out_byte", out_if.out_byte, want.data);
          if (out_if.run_end !== want.run_end)
            report_mismatch("run_end", 8'(out_if.run_end), 8'(want.run_end));
          if (out_if.string_end !== want.string_end)
            report_mismatch("string_end", 8'(out_if.string_end), 8'(want.string_end));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d bytes pending",
                 quiet_cycles, decoded_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Output ready with random stalls and on-demand long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_string();
    foreach (str_buf[i]) send_item(str_buf[i], i == str_buf.size() - 1);
    strings_sent++;
  endtask

  task automatic load_text(input string s);
    str_buf.delete();
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  // let the monitor see the last accepted item before waiting for the mirror queue to empty
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(15);
    if (d < 10) return 8'h30 + 8'(d);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] pair_lead();
    case ($urandom_range(6))
      0:       return CHAR_SPACE;
      1:       return 8'($urandom_range(CHAR_TAB, CHAR_CR));
      2:       return CHAR_PLUS;
      3:       return CHAR_MINUS;
      4:       return CHAR_PERCENT;
      5:       return hex_char();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pair_tail();
    int k;
    k = $urandom_range(9);
    if (k < 7) return hex_char();
    if (k == 7) return CHAR_PERCENT;
    return 8'($urandom_range(255));
  endfunction

  // Well-formed and malformed escapes, plus signs and random bytes; some strings are raw noise
  task automatic build_random_string();
    int n_tok;
    int kind;
    str_buf.delete();
    n_tok = $urandom_range(1, 5);
    if ($urandom_range(99) < 15) begin
      repeat (n_tok) begin
        if ($urandom_range(3) == 0) str_buf.push_back(CHAR_PERCENT);
        else str_buf.push_back(8'($urandom_range(255)));
      end
    end else begin
      repeat (n_tok) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          str_buf.push_back(CHAR_PERCENT);
          str_buf.push_back(hex_char());
          str_buf.push_back(hex_char());
        end else if (kind < 55) begin
          str_buf.push_back(CHAR_PERCENT);
          str_buf.push_back(pair_lead());
          str_buf.push_back(pair_tail());
        end else if (kind < 65) begin
          str_buf.push_back(CHAR_PLUS);
        end else if (kind < 90) begin
          str_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else begin
          str_buf.push_back(8'($urandom_range(255)));
        end
      end
    end
  endtask

  task automatic test_directed();
    str_buf = '{8'h00, 8'hFF, CHAR_PLUS};
    send_string();
    load_text("%4a%4g");      // two digits, then one digit and a non-digit
    send_string();
    load_text("%\0157%-1");   // whitespace lead, negative value
    send_string();
    load_text("%%41");        // invalid pair restarts on second percent
    send_string();
    load_text("%z%");         // invalid pair, replayed percent is final
    send_string();
    load_text("%4");          // percent followed only by the final byte
    send_string();
    load_text("%");           // final percent
    send_string();
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      build_random_string();
      send_string();
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    int keep;
    keep         = src_idle_pct;
    src_idle_pct = 0;
    hold_len     = HOLD_CYCLES;
    hold_seq++;
    load_text("%41%%2x+b%-f% 3%");
    send_string();
    src_idle_pct = keep;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (6) begin
      build_random_string();
      send_string();
      wait_drained();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = 8'h00;
    in_if.in_last  = 1'b0;
    esc_phase      = PH_PLAIN;
    pair_first     = 8'h00;
    src_idle_pct   = 32;
    sink_idle_pct  = 86;
    hold_seq       = 0;
    hold_len       = 0;
    fail_count     = 0;
    items_sent     = 0;
    items_taken    = 0;
    bytes_checked  = 0;
    strings_sent   = 0;
    quiet_cycles   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(22);

    src_idle_pct  = 86;
    sink_idle_pct = 32;
    test_random(22);
    test_backpressure();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random(22);
    test_drain_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $display("ERROR: %0d decoded bytes never arrived", decoded_q.size());
      fail_count++;
    end
    $display("Covered %0d strings, %0d items in, %0d decoded bytes checked",
             strings_sent, items_taken, bytes_checked);
    $display("Stall mixes: source-heavy, sink-heavy, none; plus a long sink hold-off");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
